FILE: design/irptw_pkg.sv
// shared types and constants for the ir pulse code to timing word converter
`default_nettype none

package irptw_pkg;

    // result kinds carried on the output tuser
    typedef enum logic [1:0] {
        KIND_CARRIER = 2'd0,
        KIND_TIMING  = 2'd1,
        KIND_TRAILER = 2'd2
    } t_kind;

    // trailer status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_SHORT        = 2'd1,
        ST_ZERO_CARRIER = 2'd2,
        ST_CLIPPED      = 2'd3
    } t_stat;

    // which result the output register loads
    typedef enum logic [1:0] {
        SEL_CARRIER = 2'd0,
        SEL_FILL    = 2'd1,
        SEL_REM     = 2'd2,
        SEL_TRAIL   = 2'd3
    } t_out_sel;

    // commands from the controller to the datapath
    typedef struct packed {
        logic     capture;
        logic     div_start;
        logic     mul_first;
        logic     mul_second;
        logic     load_out;
        t_out_sel out_sel;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_carrier;
        logic is_time;
        logic is_on;
        logic last;
        logic carrier_zero;
        logic div_done;
        logic t_over;
        logic fill_more;
    } t_sts;

    localparam int unsigned WORD_W    = 16;
    localparam int unsigned PROD_W    = 32;
    localparam int unsigned TIME_W    = 30;
    localparam int unsigned SCALED_W  = PROD_W + 14;
    localparam int unsigned DIV_W     = 23;

    localparam logic [14:0]       SPAN        = 15'h7FFF;
    localparam logic [13:0]       TIME_SCALE  = 14'd15625;
    localparam logic [DIV_W-1:0]  CARRIER_NUM = 23'd4194304;
    localparam logic [WORD_W-1:0] IDX_CARRIER = 16'd1;
    localparam logic [WORD_W-1:0] IDX_FIRST_T = 16'd4;
    localparam logic [WORD_W-1:0] IDX_MIN_OK  = 16'd7;
    localparam logic [WORD_W-1:0] WORD_MAX    = 16'hFFFF;

endpackage

`default_nettype wire

FILE: design/irptw_div.sv
// restoring divider, one quotient bit per cycle, for the carrier code
`default_nettype none

module irptw_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [irptw_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [irptw_pkg::DIV_W-1:0]  i_divisor,
    output logic      [irptw_pkg::WORD_W-1:0] o_quotient,
    output logic                              o_done
);
    import irptw_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_q;
    logic [DIV_W-1:0] r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   diff;
    logic             ge;

    // trial subtract of the shifted partial remainder
    always_comb begin
        rem_sh = {r_rem, r_q[DIV_W-1]};
        diff   = rem_sh - {1'b0, r_dsr};
        ge     = rem_sh >= {1'b0, r_dsr};
    end

    // control: busy for one step per dividend bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath: remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            r_q   <= {r_q[DIV_W-2:0], ge};
        end
    end

    assign o_quotient = r_q[WORD_W-1:0];
    assign o_done     = r_done;

endmodule

`default_nettype wire

FILE: design/irptw_ctrl.sv
// controller state machine: sequences decode, divide, multiply and result output
`default_nettype none

module irptw_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    input  wire logic            i_m_tready,
    input  wire irptw_pkg::t_sts i_sts,
    output irptw_pkg::t_cmd      o_cmd
);
    import irptw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_CAR_OUT,
        S_MUL1,
        S_MUL2,
        S_EMIT,
        S_TRAIL
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    t_cmd   cmd;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        cmd         = '0;
        out_free    = !r_out_valid || i_m_tready;
        n_out_valid = r_out_valid && !i_m_tready;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_sts.is_carrier) begin
                    if (i_sts.carrier_zero) begin
                        n_state = S_CAR_OUT;
                    end else begin
                        cmd.div_start = 1'b1;
                        n_state       = S_DIV;
                    end
                end else if (i_sts.is_time && !(i_sts.is_on && i_sts.last)) begin
                    n_state = S_MUL1;
                end else if (i_sts.last) begin
                    n_state = S_TRAIL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_CAR_OUT;
                end
            end
            S_CAR_OUT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = SEL_CARRIER;
                    n_out_valid  = 1'b1;
                    n_state      = i_sts.last ? S_TRAIL : S_IDLE;
                end
            end
            S_MUL1: begin
                cmd.mul_first = 1'b1;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul_second = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    n_out_valid  = 1'b1;
                    if (i_sts.t_over && i_sts.fill_more) begin
                        cmd.out_sel = SEL_FILL;
                    end else begin
                        cmd.out_sel = SEL_REM;
                        n_state     = i_sts.last ? S_TRAIL : S_IDLE;
                    end
                end
            end
            S_TRAIL: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = SEL_TRAIL;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = cmd;

endmodule

`default_nettype wire

FILE: design/irptw_dp.sv
// datapath: code state, carrier divide, time multiply, filler split, output register
`default_nettype none

module irptw_dp #(
    parameter int unsigned MAX_FILLER = 62
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [irptw_pkg::WORD_W-1:0] i_code_word,
    input  wire logic                         i_last_word,
    input  wire irptw_pkg::t_cmd              i_cmd,
    output irptw_pkg::t_sts                   o_sts,
    output logic      [irptw_pkg::WORD_W-1:0] o_out_word,
    output logic      [1:0]                   o_word_kind,
    output logic      [1:0]                   o_status,
    output logic                              o_last_result
);
    import irptw_pkg::*;

    localparam int unsigned FILL_W = $clog2(MAX_FILLER + 1);

    // code state
    logic [WORD_W-1:0] r_word_index;
    logic [WORD_W-1:0] r_carrier;
    logic [WORD_W-1:0] r_count;
    logic              r_clipped;
    // current item
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_idx;
    logic              r_last;
    // time arithmetic
    logic [PROD_W-1:0] r_prod;
    logic [TIME_W-1:0] r_time;
    logic [FILL_W-1:0] r_fill;
    // output register
    logic [WORD_W-1:0] r_out_word;
    logic [1:0]        r_out_kind;
    logic [1:0]        r_out_status;
    logic              r_out_last;

    logic [DIV_W-1:0]    dividend;
    logic [DIV_W-1:0]    divisor;
    logic [WORD_W-1:0]   quotient;
    logic                div_done;
    logic [SCALED_W-1:0] scaled;
    logic                is_on;
    logic                t_over;
    logic [WORD_W-1:0]   count_inc;
    logic [14:0]         rem_val;
    t_stat               trail_st;

    // carrier code = (4194304 + 50 F) / (100 F)
    always_comb begin
        dividend = CARRIER_NUM + DIV_W'(r_carrier) * DIV_W'(50);
        divisor  = DIV_W'(r_carrier) * DIV_W'(100);
    end

    irptw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    // derived values for the current item
    always_comb begin
        is_on     = !r_idx[0];
        t_over    = r_time > TIME_W'(SPAN);
        scaled    = SCALED_W'(r_prod) * SCALED_W'(TIME_SCALE);
        count_inc = (r_count == WORD_MAX) ? r_count : r_count + WORD_W'(1);
        rem_val   = t_over ? SPAN : r_time[14:0];
        priority if (r_idx < IDX_MIN_OK) begin
            trail_st = ST_SHORT;
        end else if (r_carrier == '0) begin
            trail_st = ST_ZERO_CARRIER;
        end else if (r_clipped) begin
            trail_st = ST_CLIPPED;
        end else begin
            trail_st = ST_OK;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.is_carrier   = (r_idx == IDX_CARRIER);
        o_sts.is_time      = (r_idx >= IDX_FIRST_T) && (r_idx != WORD_MAX);
        o_sts.is_on        = is_on;
        o_sts.last         = r_last;
        o_sts.carrier_zero = (r_carrier == '0);
        o_sts.div_done     = div_done;
        o_sts.t_over       = t_over;
        o_sts.fill_more    = r_fill < FILL_W'(MAX_FILLER);
    end

    // code state: index, carrier, interval count, clip flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_index <= '0;
            r_carrier    <= '0;
            r_count      <= '0;
            r_clipped    <= 1'b0;
        end else if (i_cmd.capture) begin
            if (r_word_index != WORD_MAX) begin
                r_word_index <= r_word_index + WORD_W'(1);
            end
            if (r_word_index == IDX_CARRIER) begin
                r_carrier <= i_code_word;
            end
        end else if (i_cmd.load_out) begin
            unique case (i_cmd.out_sel)
                SEL_CARRIER: ;
                SEL_FILL: begin
                    r_count <= count_inc;
                end
                SEL_REM: begin
                    r_count <= count_inc;
                    if (t_over) begin
                        r_clipped <= 1'b1;
                    end
                end
                SEL_TRAIL: begin
                    r_word_index <= '0;
                    r_carrier    <= '0;
                    r_count      <= '0;
                    r_clipped    <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // item capture and time arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_word <= i_code_word;
            r_idx  <= r_word_index;
            r_last <= i_last_word;
        end
        if (i_cmd.mul_first) begin
            r_prod <= PROD_W'(r_word) * PROD_W'(r_carrier);
        end
        if (i_cmd.mul_second) begin
            r_time <= scaled[SCALED_W-1:16];
            r_fill <= '0;
        end else if (i_cmd.load_out && i_cmd.out_sel == SEL_FILL) begin
            r_time <= r_time - TIME_W'(SPAN);
            r_fill <= r_fill + FILL_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            unique case (i_cmd.out_sel)
                SEL_CARRIER: begin
                    r_out_word   <= (r_carrier == '0) ? '0 : quotient;
                    r_out_kind   <= KIND_CARRIER;
                    r_out_status <= ST_OK;
                    r_out_last   <= !r_last;
                end
                SEL_FILL: begin
                    r_out_word   <= {is_on, SPAN};
                    r_out_kind   <= KIND_TIMING;
                    r_out_status <= ST_OK;
                    r_out_last   <= 1'b0;
                end
                SEL_REM: begin
                    r_out_word   <= {is_on, rem_val};
                    r_out_kind   <= KIND_TIMING;
                    r_out_status <= ST_OK;
                    r_out_last   <= !r_last;
                end
                SEL_TRAIL: begin
                    r_out_word   <= r_count;
                    r_out_kind   <= KIND_TRAILER;
                    r_out_status <= trail_st;
                    r_out_last   <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_out_word    = r_out_word;
    assign o_word_kind   = r_out_kind;
    assign o_status      = r_out_status;
    assign o_last_result = r_out_last;

endmodule

`default_nettype wire

FILE: design/ir_pulse_code_to_timing_words.sv
// top level: ir pulse code words in, carrier code, timing words and trailer out
// flow: an item giving no result is captured and decoded; a carrier word waits on the
//   23-step carrier divider; a burst count is multiplied twice, then emits its fillers and
//   remainder, one output register load per word; a last word adds the trailer.
// throughput: one item at a time; the next item is taken when the controller is idle.
// reset: synchronous active low, clears controller, output valid and the code state.
`default_nettype none

module ir_pulse_code_to_timing_words #(
    parameter int unsigned MAX_FILLER = 62
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [15:0] code_word
    input  wire logic        i_s_tlast,   // last_word
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [23:0] o_m_tdata,   // [15:0] out_word, [17:16] status, [23:18] zero
    output logic      [1:0]  o_m_tuser,   // [1:0] word_kind
    output logic             o_m_tlast    // last_result
);
    import irptw_pkg::*;

    t_cmd              cmd;
    t_sts              sts;
    logic [WORD_W-1:0] out_word;
    logic [1:0]        out_status;

    irptw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    irptw_dp #(
        .MAX_FILLER (MAX_FILLER)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_code_word   (i_s_tdata),
        .i_last_word   (i_s_tlast),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_word    (out_word),
        .o_word_kind   (o_m_tuser),
        .o_status      (out_status),
        .o_last_result (o_m_tlast)
    );

    assign o_m_tdata = {6'b0, out_status, out_word};

endmodule

`default_nettype wire

FILE: design/irptw_checker.sv
// port-level checker for the converter, bound to the top level
`default_nettype none

module irptw_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [23:0] o_m_tdata,
    input wire logic [1:0]  o_m_tuser,
    input wire logic        o_m_tlast
);
    import irptw_pkg::*;

    // a stalled result request keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output request changed while stalled");

    // only defined kinds are sent
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser != 2'd3)
        else $error("undefined result kind");

    // status is zero except on a trailer
    a_status_trailer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != KIND_TRAILER |-> o_m_tdata[17:16] == ST_OK)
        else $error("status on a non-trailer result");

    // a trailer always closes the results of its item
    a_trailer_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_TRAILER |-> o_m_tlast)
        else $error("trailer without last flag");

    // the pad bits of tdata stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[23:18] == 6'd0)
        else $error("tdata pad bits set");

endmodule

bind ir_pulse_code_to_timing_words irptw_checker u_irptw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

FILE: tb/tb_ir_pulse_code_to_timing_words.sv
// testbench for the ir pulse code to timing word converter: random codes checked against a predictor
module tb_ir_pulse_code_to_timing_words;
    timeunit 1ns;
    timeprecision 1ps;

    import irptw_pkg::*;

    localparam int unsigned FILLER_LIMIT = 62;
    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    localparam int unsigned RANDOM_WORDS = 130;

    // one code word waiting to be sent, with its lead-in gap
    typedef struct {
        logic [15:0] word;
        logic        fin;
        int unsigned gap;
        bit          drain;
        bit          quiet;
    } code_item_t;

    // one result word the converter owes us
    typedef struct {
        logic [15:0] word;
        t_kind       kind;
        t_stat       stat;
        logic        fin;
    } owed_word_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;   // [15:0] code_word
    logic        i_s_tlast = 1'b0; // last_word
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;        // [15:0] out_word, [17:16] status, [23:18] zero
    logic [1:0]  o_m_tuser;        // [1:0] word_kind
    logic        o_m_tlast;        // last_result

    code_item_t  code_q[$];
    owed_word_t  owed_words[$];

    // converter state as the predictor sees it
    logic [15:0] pos_idx = '0;
    logic [15:0] carrier_f = '0;
    logic [15:0] words_sent = '0;
    logic        clip_hit = 1'b0;
    logic [15:0] on_count = '0;

    int unsigned results_due = 0;
    int unsigned results_seen = 0;
    int unsigned err_cnt = 0;
    int unsigned cycle_cnt = 0;
    bit          stim_done = 1'b0;
    bit          quiet_run = 1'b0;
    bit          gaps_off = 1'b0;
    bit          drain_next = 1'b0;
    bit          sink_busy_mode = 1'b1;
    int unsigned sink_stall = 0;

    ir_pulse_code_to_timing_words #(
        .MAX_FILLER(FILLER_LIMIT)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // nonzero idle length: mostly short, now and then long
    function automatic int unsigned pick_stall_len();
        if ($urandom_range(99) < 80) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // work out the result words one code word produces, and queue them
    function automatic int unsigned convert_word(input logic [15:0] w, input logic fin);
        owed_word_t  res[$];
        owed_word_t  r;
        logic [15:0] idx;
        logic [63:0] d;
        logic [63:0] t;
        logic [63:0] span64;
        bit          on;
        int unsigned fill;
        t_stat       st;
        idx = pos_idx;
        span64 = 64'(SPAN);
        if (idx == IDX_CARRIER) begin
            // carrier word: rounded 41943.04 / F
            carrier_f = w;
            r = '{16'd0, KIND_CARRIER, ST_OK, 1'b0};
            if (w != 16'd0) begin
                d = 64'd100 * 64'(w);
                r.word = 16'((64'(CARRIER_NUM) + d / 2) / d);
            end
            res.push_back(r);
        end else if (idx >= IDX_FIRST_T && idx != WORD_MAX) begin
            // burst count: even index on, odd index off
            on = (idx[0] == 1'b0);
            if (on) on_count = w;
            if (!on || !fin) begin
                t = (64'(w) * 64'(carrier_f) * 64'(TIME_SCALE)) >> 16;
                fill = 0;
                while (t > span64 && fill < FILLER_LIMIT) begin
                    res.push_back('{on ? 16'hFFFF : {1'b0, SPAN}, KIND_TIMING, ST_OK, 1'b0});
                    t = t - span64;
                    fill++;
                end
                // clip what the filler limit could not cover
                if (t > span64) begin
                    t = span64;
                    clip_hit = 1'b1;
                end
                res.push_back('{{on, t[14:0]}, KIND_TIMING, ST_OK, 1'b0});
                foreach (res[i]) begin
                    if (words_sent != WORD_MAX) words_sent++;
                end
            end
        end
        if (pos_idx != WORD_MAX) pos_idx++;
        // trailer, then back to the start of a code
        if (fin) begin
            if (idx < IDX_MIN_OK) st = ST_SHORT;
            else if (carrier_f == 16'd0) st = ST_ZERO_CARRIER;
            else if (clip_hit) st = ST_CLIPPED;
            else st = ST_OK;
            res.push_back('{words_sent, KIND_TRAILER, st, 1'b0});
            pos_idx = '0;
            carrier_f = '0;
            words_sent = '0;
            clip_hit = 1'b0;
            on_count = '0;
        end
        if (res.size() > 0) res[res.size() - 1].fin = 1'b1;
        foreach (res[i]) owed_words.push_back(res[i]);
        return res.size();
    endfunction

    function automatic void mismatch(input string field, input int unsigned want,
                                     input int unsigned got);
        $error("%s: expected %0h, got %0h", field, want, got);
        err_cnt++;
    endfunction

    function automatic void add_word(input logic [15:0] w, input logic fin, input bit quiet);
        code_item_t it;
        it.word = w;
        it.fin = fin;
        it.quiet = quiet;
        it.drain = drain_next;
        drain_next = 1'b0;
        if (quiet || gaps_off || $urandom_range(99) < 55) it.gap = 0;
        else it.gap = pick_stall_len();
        code_q.push_back(it);
    endfunction

    function automatic void add_code(input logic [15:0] words[]);
        foreach (words[i]) add_word(words[i], i == words.size() - 1, 1'b0);
    endfunction

    // a code of random length, carrier and burst counts
    function automatic void add_random_code();
        int unsigned len;
        int unsigned r;
        int unsigned i;
        logic [15:0] f;
        logic [15:0] w;
        r = $urandom_range(99);
        if (r < 15) len = $urandom_range(1, 7);
        else if (r < 90) len = $urandom_range(8, 20);
        else len = $urandom_range(21, 40);
        r = $urandom_range(99);
        if (r < 65) f = 16'($urandom_range(16'h0060, 16'h0080));
        else if (r < 75) f = 16'h0000;
        else if (r < 85) f = 16'hFFFF;
        else f = 16'($urandom);
        gaps_off = ($urandom_range(4) == 0);
        for (i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (i == 0) w = (r < 80) ? 16'h0000 : 16'($urandom);
            else if (i == 1) w = f;
            else if (i < 4) w = (r < 70) ? 16'($urandom_range(0, 40)) : 16'($urandom);
            else if (r < 80) w = 16'($urandom_range(1, 16'h0100));
            else if (r < 93) w = 16'($urandom);
            else if (r < 97) w = 16'hFFFF;
            else w = 16'h0000;
            add_word(w, i == len - 1, 1'b0);
        end
        gaps_off = 1'b0;
    endfunction

    // request driver: lead-in gaps, drain pauses, valid held across back-to-back words
    always @(posedge i_clk) begin
        code_item_t cur;
        bit         fire;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            stim_done <= 1'b0;
            results_due <= 0;
        end else begin
            fire = i_s_tvalid && o_s_tready;
            if (fire) results_due <= results_due + convert_word(i_s_tdata, i_s_tlast);
            if (!i_s_tvalid || fire) begin
                if (code_q.size() == 0) begin
                    i_s_tvalid <= 1'b0;
                    stim_done <= 1'b1;
                end else if (code_q[0].gap != 0) begin
                    code_q[0].gap = code_q[0].gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (code_q[0].drain && (fire || results_seen != results_due)) begin
                    i_s_tvalid <= 1'b0;
                end else begin
                    cur = code_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= cur.word;
                    i_s_tlast <= cur.fin;
                    quiet_run <= cur.quiet;
                end
            end
        end
    end

    // result monitor and random back-pressure
    always @(posedge i_clk) begin
        owed_word_t want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            results_seen <= 0;
            sink_stall = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen <= results_seen + 1;
                if (owed_words.size() == 0) begin
                    mismatch("result with nothing owed, out_word", 0, o_m_tdata[15:0]);
                end else begin
                    want = owed_words.pop_front();
                    if (o_m_tdata[15:0] !== want.word)
                        mismatch("out_word", want.word, o_m_tdata[15:0]);
                    if (o_m_tuser !== want.kind)
                        mismatch("word_kind", want.kind, o_m_tuser);
                    if (o_m_tdata[17:16] !== want.stat)
                        mismatch("status", want.stat, o_m_tdata[17:16]);
                    if (o_m_tlast !== want.fin)
                        mismatch("last_result", want.fin, o_m_tlast);
                end
            end
            // alternate stretches with and without stalls
            if ($urandom_range(63) == 0) sink_busy_mode = !sink_busy_mode;
            if (sink_stall != 0) begin
                sink_stall--;
                i_m_tready <= 1'b0;
            end else if (sink_busy_mode && !quiet_run && $urandom_range(99) < 20) begin
                sink_stall = pick_stall_len() - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int unsigned base;
        // directed: F of one with an unpaired on-burst at the end
        add_code('{16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
                   16'h0001, 16'hFFFF, 16'h8001});
        // directed: largest carrier and counts, clipped
        add_code('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'h0000, 16'h0001});
        // directed: zero carrier
        add_code('{16'h0000, 16'h0000, 16'h0001, 16'h0002, 16'hFFFF, 16'hFFFF,
                   16'h1234, 16'h5678});
        // directed: a code of a single word
        add_code('{16'hFFFF});
        base = code_q.size();
        drain_next = 1'b1;
        while (code_q.size() < base + RANDOM_WORDS) add_random_code();
        drain_next = 1'b1;
        repeat (4) add_random_code();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(stim_done && results_seen == results_due)) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
